### rtl/core/bacp_pkg.sv
// Package with shared constants and types for the clearing price unit.
`timescale 1ns / 1ps
package bacp_pkg;
    localparam int MAX_LEVELS_DEF = 64;
    localparam int PRICE_W = 24;
    localparam int SIZE_W = 20;
    localparam int CSIZE_W = 26;
    localparam logic [PRICE_W-1:0] PRICE_TOP = {PRICE_W{1'b1}};
    localparam logic [PRICE_W-1:0] PRICE_BOT = '0;
    localparam logic [CSIZE_W-1:0] CSIZE_MAX = {CSIZE_W{1'b1}};

    // Front-to-back queue entry: one level, already classified.
    typedef struct packed {
        logic                side;
        logic [PRICE_W-1:0]  price;
        logic [SIZE_W-1:0]   size;
        logic                last;
    } lvl_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BEST_RD,
        ST_BEST,
        ST_CAND_RD,
        ST_CAND,
        ST_NEXT_RD,
        ST_NEXT,
        ST_SUM_RD,
        ST_SUM,
        ST_EVAL,
        ST_OUT
    } bk_state_t;
endpackage

### rtl/core/batch_auction_clearing_price_unit.sv
// Top level of the batch auction clearing price unit.
// Usage: levels of one batch arrive on the input channel (valid/stall),
// one per item, the last one marked by last_level. Bid and ask levels are
// stored in separate level memories. After the last level the back end
// finds the best limit bid and ask (one pass over all levels) and, when
// the book crosses, walks the price union upward: each step finds the
// next price (one pass over all levels) and sums demand and supply at it
// (another pass). Levels load one per cycle while the back end is in its
// load state, not while it scans a batch.
// One result item, or none when the book does not cross, goes into the
// output register and is held there while out_stall is high. The back end
// meanwhile loads and scans the next batch and waits only when that
// batch's result is ready before the held one has left; new levels then
// wait in the two-entry front queue. Reset clears the level counts, the
// drop flag and the stored last clearing price to zero.
`timescale 1ns / 1ps
module batch_auction_clearing_price_unit #(
    parameter int MAX_LEVELS = bacp_pkg::MAX_LEVELS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic side,
    input  logic is_market,
    input  logic [bacp_pkg::PRICE_W-1:0] level_price,
    input  logic [bacp_pkg::SIZE_W-1:0]  level_size,
    input  logic last_level,
    output logic out_valid,
    input  logic out_stall,
    output logic crossed,
    output logic [bacp_pkg::PRICE_W-1:0] clear_price,
    output logic [bacp_pkg::CSIZE_W-1:0] clear_size,
    output logic overflow
);
    import bacp_pkg::*;

    logic q_valid, q_pop;
    lvl_t q_data;

    bacp_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .stall(in_stall),
        .side(side), .is_market(is_market), .level_price(level_price),
        .level_size(level_size), .last_level(last_level),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data));

    bacp_back #(.MAX_LEVELS(MAX_LEVELS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
        .valid_o(out_valid), .stall_o(out_stall), .crossed(crossed),
        .clear_price(clear_price), .clear_size(clear_size), .overflow(overflow));
endmodule

### rtl/core/bacp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bacp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### rtl/core/bacp_front.sv
// Input front: maps market levels to extreme prices and fills a small queue.
`timescale 1ns / 1ps
module bacp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    output logic            stall,
    input  logic            side,
    input  logic            is_market,
    input  logic [bacp_pkg::PRICE_W-1:0] level_price,
    input  logic [bacp_pkg::SIZE_W-1:0]  level_size,
    input  logic            last_level,
    output logic            q_valid,
    input  logic            q_pop,
    output bacp_pkg::lvl_t  q_data
);
    import bacp_pkg::*;

    lvl_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rp_reg, wp_reg;
    logic       push, pop;
    lvl_t       in_lvl;

    always_comb
    begin
        in_lvl.side  = side;
        in_lvl.size  = level_size;
        in_lvl.last  = last_level;
        if (is_market)
        begin
            in_lvl.price = side ? PRICE_BOT : PRICE_TOP;
        end
        else
        begin
            in_lvl.price = level_price;
        end
    end

    assign stall   = cnt_reg == 2'd2;
    assign push    = valid && !stall;
    assign q_valid = cnt_reg != 2'd0;
    assign pop     = q_pop && q_valid;
    assign q_data  = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_lvl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rp_reg  <= 1'b0;
            wp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### rtl/core/bacp_back.sv
// Back end: level stores, crossing test and upward price scan.
`timescale 1ns / 1ps
module bacp_back #(
    parameter int MAX_LEVELS = bacp_pkg::MAX_LEVELS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_pop,
    input  bacp_pkg::lvl_t  q_data,
    output logic            valid_o,
    input  logic            stall_o,
    output logic            crossed,
    output logic [bacp_pkg::PRICE_W-1:0] clear_price,
    output logic [bacp_pkg::CSIZE_W-1:0] clear_size,
    output logic            overflow
);
    import bacp_pkg::*;

    localparam int AW = $clog2(MAX_LEVELS);
    localparam int CW = $clog2(MAX_LEVELS + 1);
    localparam int SW = SIZE_W + CW;
    localparam int XW = (SW > CSIZE_W ? SW : CSIZE_W);

    bk_state_t st_reg, st_next;

    logic [CW-1:0] bcnt_reg, acnt_reg;
    logic          drop_reg;
    logic [PRICE_W-1:0] prior_reg;

    // Shared scan index across both stores: first bids then asks.
    logic [CW:0]   idx_reg;
    logic          have_bid_reg, have_ask_reg;
    logic [PRICE_W-1:0] best_bid_reg, best_ask_reg;

    logic [PRICE_W-1:0] cur_reg;     // price being evaluated
    logic          have_cand_reg;
    logic [PRICE_W-1:0] cand_reg;    // next larger price found in the walk
    logic [SW-1:0] dem_reg, sup_reg;
    logic          started_reg;
    logic [SW-1:0] bvol_reg, bexc_reg;
    logic [PRICE_W-1:0] bpx_reg;

    logic          ov_reg, ovf_reg;
    logic [PRICE_W-1:0] op_reg;
    logic [CSIZE_W-1:0] os_reg;

    logic          bwr, awr;
    logic [AW-1:0] rd_addr;
    logic [PRICE_W-1:0] bp_rd, ap_rd;
    logic [SIZE_W-1:0]  bs_rd, as_rd;

    logic          in_bid;       // index points into bid store
    logic          idx_done;
    logic [CW:0]   tot;
    logic [CW:0]   idx_m;

    assign tot    = {1'b0, bcnt_reg} + {1'b0, acnt_reg};
    assign in_bid = idx_reg < {1'b0, bcnt_reg};
    assign idx_m  = in_bid ? idx_reg : idx_reg - {1'b0, bcnt_reg};
    assign rd_addr = idx_m[AW-1:0];
    assign idx_done = idx_reg >= tot;

    assign q_pop = (st_reg == ST_LOAD) && q_valid;
    assign bwr = q_pop && !q_data.side && (bcnt_reg < CW'(MAX_LEVELS));
    assign awr = q_pop &&  q_data.side && (acnt_reg < CW'(MAX_LEVELS));

    bacp_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_LEVELS)) u_bp (
        .clk(clk), .wr_en(bwr), .wr_addr(bcnt_reg[AW-1:0]), .wr_data(q_data.price),
        .rd_addr(rd_addr), .rd_data(bp_rd));
    bacp_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_LEVELS)) u_bs (
        .clk(clk), .wr_en(bwr), .wr_addr(bcnt_reg[AW-1:0]), .wr_data(q_data.size),
        .rd_addr(rd_addr), .rd_data(bs_rd));
    bacp_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_LEVELS)) u_ap (
        .clk(clk), .wr_en(awr), .wr_addr(acnt_reg[AW-1:0]), .wr_data(q_data.price),
        .rd_addr(rd_addr), .rd_data(ap_rd));
    bacp_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_LEVELS)) u_as (
        .clk(clk), .wr_en(awr), .wr_addr(acnt_reg[AW-1:0]), .wr_data(q_data.size),
        .rd_addr(rd_addr), .rd_data(as_rd));

    // Registered copy of which store the read came from.
    logic rd_bid_reg;
    logic [PRICE_W-1:0] rp;
    logic [SIZE_W-1:0]  rs;
    assign rp = rd_bid_reg ? bp_rd : ap_rd;
    assign rs = rd_bid_reg ? bs_rd : as_rd;

    // Evaluation of current price against best so far.
    logic [SW-1:0] vol, exc;
    logic [PRICE_W-1:0] d_cur, d_best;
    logic take, stop;
    always_comb
    begin
        vol = (dem_reg < sup_reg) ? dem_reg : sup_reg;
        exc = (dem_reg >= sup_reg) ? dem_reg - sup_reg : sup_reg - dem_reg;
        d_cur  = (cur_reg >= prior_reg) ? cur_reg - prior_reg : prior_reg - cur_reg;
        d_best = (bpx_reg >= prior_reg) ? bpx_reg - prior_reg : prior_reg - bpx_reg;
        take = 1'b0;
        stop = 1'b0;
        priority if (!started_reg || vol > bvol_reg)
        begin
            take = 1'b1;
        end
        else if (vol == bvol_reg)
        begin
            take = (exc < bexc_reg) || (exc == bexc_reg && d_cur < d_best);
        end
        else
        begin
            stop = 1'b1;
        end
    end

    logic crosses;
    assign crosses = have_bid_reg && have_ask_reg && (best_bid_reg >= best_ask_reg);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_LOAD:    if (q_pop && q_data.last) st_next = ST_BEST_RD;
            ST_BEST_RD: st_next = idx_done ? ST_CAND_RD : ST_BEST;
            ST_BEST:    st_next = ST_BEST_RD;
            ST_CAND_RD: st_next = crosses ? ST_NEXT_RD : ST_LOAD;
            ST_CAND:    st_next = ST_NEXT_RD;
            ST_NEXT_RD: st_next = idx_done ? (have_cand_reg ? ST_SUM_RD : ST_OUT) : ST_NEXT;
            ST_NEXT:    st_next = ST_NEXT_RD;
            ST_SUM_RD:  st_next = idx_done ? ST_EVAL : ST_SUM;
            ST_SUM:     st_next = ST_SUM_RD;
            ST_EVAL:    st_next = stop ? ST_OUT : ST_NEXT_RD;
            ST_OUT:     if (!ov_reg || !stall_o) st_next = ST_LOAD;
            default:    st_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_LOAD;
            bcnt_reg <= '0;
            acnt_reg <= '0;
            drop_reg <= 1'b0;
            prior_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (bwr) bcnt_reg <= bcnt_reg + CW'(1);
            if (awr) acnt_reg <= acnt_reg + CW'(1);
            if (q_pop && !bwr && !awr) drop_reg <= 1'b1;
            if (st_reg == ST_CAND_RD && !crosses)
            begin
                bcnt_reg <= '0;
                acnt_reg <= '0;
                drop_reg <= 1'b0;
            end
            // The finished result moves into the output register once it is free.
            if (st_reg == ST_OUT && st_next == ST_LOAD)
            begin
                bcnt_reg  <= '0;
                acnt_reg  <= '0;
                drop_reg  <= 1'b0;
                prior_reg <= bpx_reg;
                ov_reg    <= 1'b1;
            end
            else if (!stall_o)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        rd_bid_reg <= in_bid;
        unique case (st_reg)
            ST_LOAD:
            begin
                idx_reg <= '0;
                have_bid_reg <= 1'b0;
                have_ask_reg <= 1'b0;
            end
            ST_BEST_RD: ;
            ST_BEST:
            begin
                if (rd_bid_reg)
                begin
                    if (rp != PRICE_TOP && (!have_bid_reg || rp > best_bid_reg))
                    begin
                        best_bid_reg <= rp;
                        have_bid_reg <= 1'b1;
                    end
                end
                else if (rp != PRICE_BOT && (!have_ask_reg || rp < best_ask_reg))
                begin
                    best_ask_reg <= rp;
                    have_ask_reg <= 1'b1;
                end
                idx_reg <= idx_reg + (CW+1)'(1);
            end
            ST_CAND_RD:
            begin
                // Start the walk: find the smallest price overall.
                idx_reg <= '0;
                have_cand_reg <= 1'b0;
                started_reg <= 1'b0;
                cur_reg <= PRICE_BOT;
                bvol_reg <= '0;
                bexc_reg <= '0;
                bpx_reg <= '0;
            end
            ST_CAND: ;
            ST_NEXT_RD:
            begin
                if (idx_done)
                begin
                    idx_reg <= '0;
                    cur_reg <= cand_reg;
                    dem_reg <= '0;
                    sup_reg <= '0;
                end
            end
            ST_NEXT:
            begin
                // Smallest price above the current one (or at least lowest on first pass).
                if ((!started_reg ? 1'b1 : rp > cur_reg) &&
                    (!have_cand_reg || rp < cand_reg))
                begin
                    cand_reg <= rp;
                    have_cand_reg <= 1'b1;
                end
                idx_reg <= idx_reg + (CW+1)'(1);
            end
            ST_SUM_RD: ;
            ST_SUM:
            begin
                if (rd_bid_reg && rp >= cur_reg) dem_reg <= dem_reg + SW'(rs);
                if (!rd_bid_reg && rp <= cur_reg) sup_reg <= sup_reg + SW'(rs);
                idx_reg <= idx_reg + (CW+1)'(1);
            end
            ST_EVAL:
            begin
                if (take)
                begin
                    bvol_reg <= vol;
                    bexc_reg <= exc;
                    bpx_reg  <= cur_reg;
                end
                started_reg <= 1'b1;
                have_cand_reg <= 1'b0;
                idx_reg <= '0;
            end
            ST_OUT: ;
            default: ;
        endcase
        if (st_reg == ST_OUT && (!ov_reg || !stall_o))
        begin
            op_reg <= bpx_reg;
            os_reg <= (XW'(bvol_reg) > XW'(CSIZE_MAX)) ? CSIZE_MAX : CSIZE_W'(bvol_reg);
            ovf_reg <= drop_reg;
        end
    end

    assign valid_o     = ov_reg;
    assign crossed     = 1'b1;
    assign clear_price = op_reg;
    assign clear_size  = os_reg;
    assign overflow    = ovf_reg;
endmodule

### rtl/core/bacp_checker.sv
// Port-level checker for the clearing price unit, bound to the top level.
`timescale 1ns / 1ps
module bacp_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic crossed,
    input logic [bacp_pkg::PRICE_W-1:0] clear_price,
    input logic [bacp_pkg::CSIZE_W-1:0] clear_size
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(clear_price) && $stable(clear_size))
        else $error("result changed while stalled");
    a_crossed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> crossed)
        else $error("result without crossed flag");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({clear_price, clear_size}))
        else $error("result with unknown bits");
endmodule

bind batch_auction_clearing_price_unit bacp_checker u_bacp_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_valid), .out_stall(out_stall), .crossed(crossed),
    .clear_price(clear_price), .clear_size(clear_size));

### tb/batch_auction_clearing_price_checker.sv
// Checker that predicts and compares the clearing results of the auction unit.
`timescale 1ns / 1ps
module batch_auction_clearing_price_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_stall,
    input  logic side,
    input  logic is_market,
    input  logic [bacp_pkg::PRICE_W-1:0] level_price,
    input  logic [bacp_pkg::SIZE_W-1:0]  level_size,
    input  logic last_level,
    input  logic out_valid,
    input  logic out_stall,
    input  logic crossed,
    input  logic [bacp_pkg::PRICE_W-1:0] clear_price,
    input  logic [bacp_pkg::CSIZE_W-1:0] clear_size,
    input  logic overflow,
    output int   fail_count,
    output int   pending_clears,
    output int   batch_count,
    output int   clear_count,
    output int   overflow_count
);
    import bacp_pkg::*;

    localparam int DEPTH = MAX_LEVELS_DEF;
    localparam int EXP_DEPTH = 64;

    typedef struct {
        logic [PRICE_W-1:0] price;
        logic [CSIZE_W-1:0] volume;
        logic               dropped;
    } clearing_t;

    logic [PRICE_W-1:0] bid_px [DEPTH];
    logic [SIZE_W-1:0]  bid_sz [DEPTH];
    logic [PRICE_W-1:0] ask_px [DEPTH];
    logic [SIZE_W-1:0]  ask_sz [DEPTH];
    int                 bid_n;
    int                 ask_n;
    logic [PRICE_W-1:0] last_clear_px;
    logic               levels_dropped;
    clearing_t          expected_clears [EXP_DEPTH];
    int                 exp_wr;
    int                 exp_rd;

    function automatic longint px_dist(logic [PRICE_W-1:0] a, logic [PRICE_W-1:0] b);
        return (a >= b) ? longint'(a) - longint'(b) : longint'(b) - longint'(a);
    endfunction

    // Runs the call auction over the stored book; returns 1 when it crosses.
    function automatic bit clear_book(output clearing_t res);
        logic [PRICE_W-1:0] prices [2*DEPTH];
        logic [PRICE_W-1:0] p;
        logic [PRICE_W-1:0] top_bid, low_ask, best_px;
        bit                 have_bid, have_ask, dup, started;
        int                 n, i, j;
        longint             dem, sup, vol, exc, best_vol, best_exc;
        have_bid = 0;
        have_ask = 0;
        top_bid = '0;
        low_ask = '0;
        n = 0;
        started = 0;
        best_vol = 0;
        best_exc = 0;
        best_px = '0;
        res.price = '0;
        res.volume = '0;
        res.dropped = 0;
        for (i = 0; i < bid_n; i++)
        begin
            if (bid_px[i] != PRICE_TOP && (!have_bid || bid_px[i] > top_bid))
            begin
                top_bid = bid_px[i];
                have_bid = 1;
            end
        end
        for (i = 0; i < ask_n; i++)
        begin
            if (ask_px[i] != PRICE_BOT && (!have_ask || ask_px[i] < low_ask))
            begin
                low_ask = ask_px[i];
                have_ask = 1;
            end
        end
        if (!have_bid || !have_ask || top_bid < low_ask)
            return 0;
        for (i = 0; i < bid_n + ask_n; i++)
        begin
            p = (i < bid_n) ? bid_px[i] : ask_px[i - bid_n];
            dup = 0;
            for (j = 0; j < n; j++)
                if (prices[j] == p)
                    dup = 1;
            if (!dup)
            begin
                j = n;
                while (j > 0 && prices[j-1] > p)
                begin
                    prices[j] = prices[j-1];
                    j--;
                end
                prices[j] = p;
                n++;
            end
        end
        for (i = 0; i < n; i++)
        begin
            p = prices[i];
            dem = 0;
            sup = 0;
            for (j = 0; j < bid_n; j++)
                if (bid_px[j] >= p)
                    dem += bid_sz[j];
            for (j = 0; j < ask_n; j++)
                if (ask_px[j] <= p)
                    sup += ask_sz[j];
            vol = (dem < sup) ? dem : sup;
            exc = (dem >= sup) ? dem - sup : sup - dem;
            if (!started || vol > best_vol)
            begin
                best_vol = vol;
                best_exc = exc;
                best_px = p;
                started = 1;
            end
            else if (vol == best_vol)
            begin
                if (exc < best_exc)
                begin
                    best_exc = exc;
                    best_px = p;
                end
                else if (exc == best_exc &&
                         px_dist(p, last_clear_px) < px_dist(best_px, last_clear_px))
                    best_px = p;
            end
            else
                break;
        end
        res.price = best_px;
        res.volume = (best_vol > longint'(CSIZE_MAX)) ? CSIZE_MAX : best_vol[CSIZE_W-1:0];
        res.dropped = levels_dropped;
        return 1;
    endfunction

    assign pending_clears = exp_wr - exp_rd;

    always @(posedge clk or negedge rst_n)
    begin
        clearing_t exp_c;
        clearing_t got;
        logic [PRICE_W-1:0] px;
        if (!rst_n)
        begin
            bid_n = 0;
            ask_n = 0;
            last_clear_px = '0;
            levels_dropped = 0;
            exp_wr = 0;
            exp_rd = 0;
            fail_count <= 0;
            batch_count <= 0;
            clear_count <= 0;
            overflow_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (exp_wr == exp_rd)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result price=%0d size=%0d ovf=%0b",
                                 clear_price, clear_size, overflow);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_c = expected_clears[exp_rd % EXP_DEPTH];
                    exp_rd = exp_rd + 1;
                    if (crossed !== 1'b1 || clear_price !== exp_c.price ||
                        clear_size !== exp_c.volume || overflow !== exp_c.dropped)
                    begin
                        if (fail_count < 10)
                            $display({"ERROR: result mismatch: expected crossed=1 ",
                                      "price=%0d size=%0d ovf=%0b, got crossed=%0b ",
                                      "price=%0d size=%0d ovf=%0b"},
                                     exp_c.price, exp_c.volume, exp_c.dropped,
                                     crossed, clear_price, clear_size, overflow);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                // Blocking updates here so the prediction sees this item.
                if (side == 1'b0)
                begin
                    px = is_market ? PRICE_TOP : level_price;
                    if (bid_n < DEPTH)
                    begin
                        bid_px[bid_n] = px;
                        bid_sz[bid_n] = level_size;
                        bid_n = bid_n + 1;
                    end
                    else
                        levels_dropped = 1;
                end
                else
                begin
                    px = is_market ? PRICE_BOT : level_price;
                    if (ask_n < DEPTH)
                    begin
                        ask_px[ask_n] = px;
                        ask_sz[ask_n] = level_size;
                        ask_n = ask_n + 1;
                    end
                    else
                        levels_dropped = 1;
                end
                if (last_level)
                begin
                    if (clear_book(got))
                    begin
                        expected_clears[exp_wr % EXP_DEPTH] = got;
                        exp_wr = exp_wr + 1;
                        last_clear_px = got.price;
                        clear_count <= clear_count + 1;
                        if (got.dropped)
                            overflow_count <= overflow_count + 1;
                    end
                    batch_count <= batch_count + 1;
                    bid_n = 0;
                    ask_n = 0;
                    levels_dropped = 0;
                end
            end
        end
    end
endmodule

### tb/batch_auction_clearing_price_unit_tb.sv
// Testbench top: drives level batches into the clearing price unit and reports.
`timescale 1ns / 1ps
module batch_auction_clearing_price_unit_tb;
    import bacp_pkg::*;

    localparam int IDLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 600;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic side;
    logic is_market;
    logic [PRICE_W-1:0] level_price;
    logic [SIZE_W-1:0]  level_size;
    logic last_level;
    logic out_valid;
    logic out_stall;
    logic crossed;
    logic [PRICE_W-1:0] clear_price;
    logic [CSIZE_W-1:0] clear_size;
    logic overflow;

    int   fail_count;
    int   pending_clears;
    int   batch_count;
    int   clear_count;
    int   overflow_count;
    int   levels_sent;
    int   idle_cycles;
    logic level_taken;
    int   hold_req;

    batch_auction_clearing_price_unit dut (.*);

    batch_auction_clearing_price_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Registered view of the input handshake, read at the falling edge.
    always @(posedge clk)
        level_taken <= in_valid && !in_stall;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result side: random stalls, with one long hold-off on request.
    initial
    begin
        int n;
        int hold_seen;
        out_stall = 0;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                out_stall <= 1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 0;
            end
            else
            begin
                n = gap_len();
                out_stall <= (n != 0);
                repeat (n) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic send_level(input logic s, input logic m, input logic [PRICE_W-1:0] p,
                              input logic [SIZE_W-1:0] z, input logic l, input bit gaps);
        int n;
        if (gaps)
        begin
            n = gap_len();
            if (n != 0)
            begin
                in_valid <= 0;
                repeat (n) @(negedge clk);
            end
        end
        in_valid <= 1;
        side <= s;
        is_market <= m;
        level_price <= p;
        level_size <= z;
        last_level <= l;
        do
            @(negedge clk);
        while (!level_taken);
        levels_sent++;
    endtask

    // One batch of n levels around a random center; noise gives fully random prices.
    task automatic send_batch(input int n, input bit noise, input bit gaps);
        logic [PRICE_W-1:0] center;
        int  spread;
        longint p;
        logic s;
        logic [SIZE_W-1:0] z;
        center = $urandom_range(1, 16777214);
        case ($urandom_range(0, 3))
            0: spread = 2;
            1: spread = 50;
            2: spread = 5000;
            default: spread = 1 << 22;
        endcase
        for (int i = 0; i < n; i++)
        begin
            s = (i == 0) ? 1'b0 : (i == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            p = longint'(center) + $urandom_range(0, 2 * spread) - spread;
            if (noise || $urandom_range(0, 19) == 0)
                p = $urandom_range(0, 16777215);
            else if (p < 1)
                p = 1;
            else if (p > 16777214)
                p = 16777214;
            z = ($urandom_range(0, 1) == 1) ? 20'($urandom_range(0, 1048575))
                                             : 20'($urandom_range(0, 8));
            send_level(s, ($urandom_range(0, 11) == 0), p[PRICE_W-1:0], z, i == n - 1, gaps);
        end
    endtask

    initial
    begin
        int n;
        bit hold_done;
        bit pause_done;
        rst_n = 0;
        in_valid = 0;
        side = 0;
        is_market = 0;
        level_price = '0;
        level_size = '0;
        last_level = 0;
        hold_req = 0;
        hold_done = 0;
        pause_done = 0;
        levels_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Plain cross.
        send_level(0, 0, 100, 10, 0, 1);
        send_level(1, 0, 90, 10, 1, 1);
        // Market levels on both sides and the price and size extremes.
        send_level(0, 1, 24'h000123, 20'hFFFFF, 0, 1);
        send_level(0, 0, 24'hFFFFFE, 1, 0, 1);
        send_level(1, 0, 1, 20'hFFFFF, 0, 1);
        send_level(1, 1, 24'hABCDEF, 20'hFFFFF, 1, 1);
        // Book that does not cross.
        send_level(0, 0, 50, 7, 0, 1);
        send_level(1, 0, 60, 7, 1, 1);
        // A bid limit at the top price counts as market, so no limit bid remains.
        send_level(1, 0, 3, 4, 0, 1);
        send_level(0, 0, 24'hFFFFFF, 9, 1, 1);
        // An ask limit at zero counts as market.
        send_level(1, 0, 0, 5, 0, 1);
        send_level(0, 0, 10, 8, 0, 1);
        send_level(1, 0, 10, 3, 1, 1);
        // Duplicate prices add up.
        send_level(0, 0, 200, 4, 0, 1);
        send_level(0, 0, 200, 6, 0, 1);
        send_level(1, 0, 200, 5, 0, 1);
        send_level(1, 0, 150, 5, 1, 1);
        // Equal volume and excess at two prices: the one nearer the last price wins.
        send_level(0, 0, 1000, 5, 0, 1);
        send_level(1, 0, 900, 5, 1, 1);
        // Zero sizes, then a lone ask that ends its batch.
        send_level(0, 0, 30, 0, 0, 1);
        send_level(1, 0, 20, 0, 1, 1);
        send_level(1, 0, 77, 12, 1, 1);

        while (levels_sent < 450)
        begin
            if (!hold_done && levels_sent > 150)
            begin
                // Hold the result side off while crossing batches keep coming.
                hold_done = 1;
                hold_req++;
                for (int b = 0; b < 6; b++)
                begin
                    send_level(0, 0, 500, 5, 0, 0);
                    send_level(1, 0, 400, 5, 1, 0);
                end
            end
            else if (!pause_done && levels_sent > 300)
            begin
                pause_done = 1;
                in_valid <= 0;
                wait (pending_clears == 0);
                @(negedge clk);
            end
            n = $urandom_range(0, 29);
            if (n == 0)
                send_batch($urandom_range(66, 72), 0, 0);
            else if (n < 4)
                send_batch($urandom_range(1, 6), 1, 1);
            else
                send_batch($urandom_range(2, 8), 0, $urandom_range(0, 3) != 0);
        end
        in_valid <= 0;

        wait (pending_clears == 0);
        repeat (5000) @(posedge clk);
        $display("Covered %0d batches, %0d of them crossed, %0d crossed with dropped levels.",
                 batch_count, clear_count, overflow_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### sim.f
rtl/core/bacp_pkg.sv
rtl/core/bacp_ram.sv
rtl/core/bacp_front.sv
rtl/core/bacp_back.sv
rtl/core/batch_auction_clearing_price_unit.sv
rtl/core/bacp_checker.sv
tb/batch_auction_clearing_price_checker.sv
tb/batch_auction_clearing_price_unit_tb.sv
